// ===== hw/rtl/rfr_pkg.sv =====
package rfr_pkg;

    // command codes of the input word
    localparam logic [1:0] CMD_CLEAR  = 2'd0;
    localparam logic [1:0] CMD_APPEND = 2'd1;
    localparam logic [1:0] CMD_QUERY  = 2'd2;

    // fixed configuration of the resampler
    localparam int FACE_VERTICES = 3;
    localparam int MAX_SAMPLES   = 4096;
    localparam int DIV_BITS      = 16;
    localparam int CNT_W         = 5;

    localparam logic [31:0] DELTA_X_RESET = 32'h0001_0000;
    localparam logic [16:0] FRAC_ONE      = 17'h1_0000;

    // datapath operation codes issued by the controller
    localparam int OP_W = 5;
    localparam logic [OP_W-1:0] DP_NOP      = 5'd0;
    localparam logic [OP_W-1:0] DP_LOAD     = 5'd1;
    localparam logic [OP_W-1:0] DP_CLEAR    = 5'd2;
    localparam logic [OP_W-1:0] DP_MAC      = 5'd3;
    localparam logic [OP_W-1:0] DP_MACEND   = 5'd4;
    localparam logic [OP_W-1:0] DP_WRITE    = 5'd5;
    localparam logic [OP_W-1:0] DP_XMUL     = 5'd6;
    localparam logic [OP_W-1:0] DP_CAPLO    = 5'd7;
    localparam logic [OP_W-1:0] DP_CAPHI    = 5'd8;
    localparam logic [OP_W-1:0] DP_SEARCH   = 5'd9;
    localparam logic [OP_W-1:0] DP_SCMP     = 5'd10;
    localparam logic [OP_W-1:0] DP_DIVINIT  = 5'd11;
    localparam logic [OP_W-1:0] DP_FRAC     = 5'd12;
    localparam logic [OP_W-1:0] DP_DIV      = 5'd13;
    localparam logic [OP_W-1:0] DP_VMUL     = 5'd14;
    localparam logic [OP_W-1:0] DP_VFIN     = 5'd15;
    localparam logic [OP_W-1:0] DP_RES_ZERO = 5'd16;
    localparam logic [OP_W-1:0] DP_RES_FULL = 5'd17;
    localparam logic [OP_W-1:0] DP_OUTLOAD  = 5'd18;

    typedef struct packed {
        logic [OP_W-1:0] op;
    } dp_cmd_t;

    typedef struct packed {
        logic [1:0] cmd;
        logic       full;
        logic       query_ok;
        logic       mac_last;
        logic       in_range;
        logic       search_more;
        logic       frac_special;
        logic       div_last;
        logic       out_free;
    } dp_stat_t;

endpackage

// ===== hw/rtl/ray_face_resampler_core.sv =====
// channel | direction | handshake             | word
// --------+-----------+-----------------------+--------------------------------------------
// in      | input     | in_valid / in_stall   | cmd, face_dist, vert_value_*, bary_*, index
// out     | output    | out_valid / out_stall | status, in_cells, segment_index, value
// cfg     | input     | cfg_wr_en             | cfg_wr_data (delta_x)
//
// one word at a time; clear goes straight to the result, append sums FACE_VERTICES
// products and writes the face ram; query runs a binary search on the face ram read port,
// a read and a compare per step, then the divider, skipped for a clamped fraction
// queries that fall outside the mesh skip the search and the divider
// reset clears the face count and loads delta_x with 1.0; the face ram is not cleared
// a finished word waits in the output register while the next input word is taken

module ray_face_resampler_core #(
    parameter int MAX_FACES = 64
) (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               cfg_wr_en,
    input  logic [31:0]        cfg_wr_data,
    input  logic               in_valid,
    output logic               in_stall,
    input  logic [1:0]         cmd,
    input  logic signed [31:0] face_dist,
    input  logic signed [31:0] vert_value_0,
    input  logic signed [31:0] vert_value_1,
    input  logic signed [31:0] vert_value_2,
    input  logic signed [17:0] bary_0,
    input  logic signed [17:0] bary_1,
    input  logic signed [17:0] bary_2,
    input  logic [11:0]        sample_index,
    output logic               out_valid,
    input  logic               out_stall,
    output logic               status,
    output logic               in_cells,
    output logic [5:0]         segment_index,
    output logic signed [31:0] sample_value
);

    import rfr_pkg::*;

    dp_cmd_t  ctl;
    dp_stat_t stat;

    rfr_ctrl u_ctrl (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (in_valid),
        .in_stall (in_stall),
        .stat     (stat),
        .ctl      (ctl)
    );

    rfr_dp #(
        .MAX_FACES (MAX_FACES)
    ) u_dp (
        .clk           (clk),
        .rst_n         (rst_n),
        .cfg_wr_en     (cfg_wr_en),
        .cfg_wr_data   (cfg_wr_data),
        .cmd           (cmd),
        .face_dist     (face_dist),
        .vert_value_0  (vert_value_0),
        .vert_value_1  (vert_value_1),
        .vert_value_2  (vert_value_2),
        .bary_0        (bary_0),
        .bary_1        (bary_1),
        .bary_2        (bary_2),
        .sample_index  (sample_index),
        .ctl           (ctl),
        .stat          (stat),
        .out_valid     (out_valid),
        .out_stall     (out_stall),
        .status        (status),
        .in_cells      (in_cells),
        .segment_index (segment_index),
        .sample_value  (sample_value)
    );

endmodule

// ===== hw/rtl/rfr_ram.sv =====
module rfr_ram #(
    parameter int WIDTH = 64,
    parameter int DEPTH = 64
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic                     re,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        if (re)
        begin
            rdata <= mem[raddr];
        end
    end

endmodule

// ===== hw/rtl/rfr_ctrl.sv =====
module rfr_ctrl (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              in_valid,
    output logic              in_stall,
    input  rfr_pkg::dp_stat_t stat,
    output rfr_pkg::dp_cmd_t  ctl
);

    import rfr_pkg::*;

    localparam logic [3:0] S_IDLE    = 4'd0;
    localparam logic [3:0] S_DECODE  = 4'd1;
    localparam logic [3:0] S_MAC     = 4'd2;
    localparam logic [3:0] S_MACEND  = 4'd3;
    localparam logic [3:0] S_WRITE   = 4'd4;
    localparam logic [3:0] S_RD0     = 4'd5;
    localparam logic [3:0] S_RDN     = 4'd6;
    localparam logic [3:0] S_OUTSIDE = 4'd7;
    localparam logic [3:0] S_SEARCH  = 4'd8;
    localparam logic [3:0] S_SCMP    = 4'd9;
    localparam logic [3:0] S_FRAC    = 4'd10;
    localparam logic [3:0] S_DIV     = 4'd11;
    localparam logic [3:0] S_VMUL    = 4'd12;
    localparam logic [3:0] S_VFIN    = 4'd13;
    localparam logic [3:0] S_DONE    = 4'd14;

    logic [3:0]      state_reg;
    logic [3:0]      state_next;
    logic [OP_W-1:0] op;

    assign in_stall = (state_reg != S_IDLE);
    assign ctl.op   = op;

    always_comb
    begin
        state_next = state_reg;
        op         = DP_NOP;
        unique case (state_reg)
            S_IDLE:
            begin
                if (in_valid)
                begin
                    op         = DP_LOAD;
                    state_next = S_DECODE;
                end
            end
            S_DECODE:
            begin
                unique case (stat.cmd)
                    CMD_CLEAR:
                    begin
                        op         = DP_CLEAR;
                        state_next = S_DONE;
                    end
                    CMD_APPEND:
                    begin
                        if (stat.full)
                        begin
                            op         = DP_RES_FULL;
                            state_next = S_DONE;
                        end
                        else
                        begin
                            state_next = S_MAC;
                        end
                    end
                    CMD_QUERY:
                    begin
                        if (stat.query_ok)
                        begin
                            op         = DP_XMUL;
                            state_next = S_RD0;
                        end
                        else
                        begin
                            op         = DP_RES_ZERO;
                            state_next = S_DONE;
                        end
                    end
                    default:
                    begin
                        op         = DP_RES_ZERO;
                        state_next = S_DONE;
                    end
                endcase
            end
            S_MAC:
            begin
                op = DP_MAC;
                if (stat.mac_last)
                begin
                    state_next = S_MACEND;
                end
            end
            S_MACEND:
            begin
                op         = DP_MACEND;
                state_next = S_WRITE;
            end
            S_WRITE:
            begin
                op         = DP_WRITE;
                state_next = S_DONE;
            end
            S_RD0:
            begin
                op         = DP_CAPLO;
                state_next = S_RDN;
            end
            S_RDN:
            begin
                op         = DP_CAPHI;
                state_next = stat.in_range ? S_SEARCH : S_OUTSIDE;
            end
            S_OUTSIDE:
            begin
                op         = DP_RES_ZERO;
                state_next = S_DONE;
            end
            S_SEARCH:
            begin
                if (stat.search_more)
                begin
                    op         = DP_SEARCH;
                    state_next = S_SCMP;
                end
                else
                begin
                    op         = DP_DIVINIT;
                    state_next = S_FRAC;
                end
            end
            S_SCMP:
            begin
                op         = DP_SCMP;
                state_next = S_SEARCH;
            end
            S_FRAC:
            begin
                op         = DP_FRAC;
                state_next = stat.frac_special ? S_VMUL : S_DIV;
            end
            S_DIV:
            begin
                op = DP_DIV;
                if (stat.div_last)
                begin
                    state_next = S_VMUL;
                end
            end
            S_VMUL:
            begin
                op         = DP_VMUL;
                state_next = S_VFIN;
            end
            S_VFIN:
            begin
                op         = DP_VFIN;
                state_next = S_DONE;
            end
            S_DONE:
            begin
                if (stat.out_free)
                begin
                    op         = DP_OUTLOAD;
                    state_next = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

endmodule

// ===== hw/rtl/rfr_dp.sv =====
module rfr_dp #(
    parameter int MAX_FACES = 64
) (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                cfg_wr_en,
    input  logic [31:0]         cfg_wr_data,
    input  logic [1:0]          cmd,
    input  logic signed [31:0]  face_dist,
    input  logic signed [31:0]  vert_value_0,
    input  logic signed [31:0]  vert_value_1,
    input  logic signed [31:0]  vert_value_2,
    input  logic signed [17:0]  bary_0,
    input  logic signed [17:0]  bary_1,
    input  logic signed [17:0]  bary_2,
    input  logic [11:0]         sample_index,
    input  rfr_pkg::dp_cmd_t    ctl,
    output rfr_pkg::dp_stat_t   stat,
    output logic                out_valid,
    input  logic                out_stall,
    output logic                status,
    output logic                in_cells,
    output logic [5:0]          segment_index,
    output logic signed [31:0]  sample_value
);

    import rfr_pkg::*;

    localparam int AW    = $clog2(MAX_FACES);
    localparam int CW    = $clog2(MAX_FACES + 1);
    localparam int EXT_W = (AW > 6) ? AW : 6;

    localparam logic signed [51:0] S32_MAX = 52'sh000007FFFFFFF;
    localparam logic signed [51:0] S32_MIN = 52'shFFFFF80000000;

    function automatic logic signed [31:0] sat32(input logic signed [51:0] a);
        logic signed [31:0] r;
        if (a > S32_MAX)
        begin
            r = S32_MAX[31:0];
        end
        else if (a < S32_MIN)
        begin
            r = S32_MIN[31:0];
        end
        else
        begin
            r = a[31:0];
        end
        return r;
    endfunction

    function automatic logic signed [45:0] ext46(input logic signed [31:0] d);
        return $signed({{14{d[31]}}, d});
    endfunction

    // control registers
    logic [31:0]      delta_x_reg;
    logic [CW-1:0]    count_reg;
    logic [CNT_W-1:0] cnt_reg;
    logic             out_valid_reg;

    // latched input word
    logic [1:0]         cmd_reg;
    logic signed [31:0] dist_in_reg;
    logic signed [31:0] vert_reg_0, vert_reg_1, vert_reg_2;
    logic signed [17:0] bary_reg_0, bary_reg_1, bary_reg_2;
    logic [11:0]        xi_reg;

    // working registers
    logic signed [49:0] prod_reg;
    logic signed [51:0] acc_reg;
    logic [43:0]        x_reg;
    logic signed [31:0] d_lo_reg, v_lo_reg, d_hi_reg, v_hi_reg;
    logic [AW-1:0]      lo_reg, hi_reg, mid_reg;
    logic signed [45:0] num_reg;
    logic signed [32:0] den_reg;
    logic signed [32:0] diff_reg;
    logic [32:0]        rem_reg;
    logic [32:0]        rem_next;
    logic [16:0]        frac_reg;
    logic signed [50:0] mprod_reg;

    logic               res_status_reg, res_in_cells_reg;
    logic [5:0]         res_seg_reg;
    logic signed [31:0] res_value_reg;
    logic               out_status_reg, out_in_cells_reg;
    logic [5:0]         out_seg_reg;
    logic signed [31:0] out_value_reg;

    // face table
    logic          ram_we, ram_re;
    logic [AW-1:0] ram_waddr, ram_raddr;
    logic [63:0]   ram_wdata, ram_rdata;
    logic signed [31:0] rd_dist, rd_val;

    logic signed [49:0] mac_prod;
    logic signed [51:0] acc_sh;
    logic signed [45:0] xs;
    logic [AW:0]        mid_sum;
    logic [AW-1:0]      mid;
    logic [AW-1:0]      last_idx;
    logic               rd_gt_x;
    logic               den_le0, num_le0, num_ge_den;
    logic [33:0]        div_t, div_den;
    logic               div_ge;
    logic signed [50:0] mprod_sh;
    logic signed [51:0] vsum;
    logic [EXT_W-1:0]   lo_ext;

    assign rd_dist   = $signed(ram_rdata[63:32]);
    assign rd_val    = $signed(ram_rdata[31:0]);
    assign xs        = $signed({2'b00, x_reg});
    assign mid_sum   = {1'b0, lo_reg} + {1'b0, hi_reg};
    assign mid       = mid_sum[AW:1];
    assign last_idx  = AW'(count_reg - CW'(1));
    assign rd_gt_x   = ext46(rd_dist) > xs;
    assign acc_sh    = acc_reg >>> 16;
    assign lo_ext    = EXT_W'(lo_reg);

    always_comb
    begin
        unique case (cnt_reg[1:0])
            2'd0:    mac_prod = vert_reg_0 * bary_reg_0;
            2'd1:    mac_prod = vert_reg_1 * bary_reg_1;
            default: mac_prod = vert_reg_2 * bary_reg_2;
        endcase
    end

    assign den_le0    = den_reg[32] || (den_reg == 33'sd0);
    assign num_le0    = num_reg[45] || (num_reg == 46'sd0);
    assign num_ge_den = num_reg >= $signed({{13{den_reg[32]}}, den_reg});

    // restoring divider, one quotient bit per cycle
    assign div_t    = {rem_reg, 1'b0};
    assign div_den  = {1'b0, den_reg[32:0]};
    assign div_ge   = div_t >= div_den;
    assign rem_next = div_ge ? 33'(div_t - div_den) : div_t[32:0];

    // v_lo + floor(frac * (v_hi - v_lo) / 2^16)
    assign mprod_sh = mprod_reg >>> 16;
    assign vsum     = $signed({{20{v_lo_reg[31]}}, v_lo_reg}) + $signed({mprod_sh[50], mprod_sh});

    assign ram_we    = (ctl.op == DP_WRITE);
    assign ram_waddr = count_reg[AW-1:0];
    assign ram_wdata = {dist_in_reg, sat32(acc_sh)};
    assign ram_re    = (ctl.op == DP_XMUL) || (ctl.op == DP_CAPLO) || (ctl.op == DP_SEARCH);

    always_comb
    begin
        unique case (ctl.op)
            DP_CAPLO:  ram_raddr = last_idx;
            DP_SEARCH: ram_raddr = mid;
            default:   ram_raddr = '0;
        endcase
    end

    rfr_ram #(
        .WIDTH (64),
        .DEPTH (MAX_FACES)
    ) u_face_ram (
        .clk   (clk),
        .we    (ram_we),
        .waddr (ram_waddr),
        .wdata (ram_wdata),
        .re    (ram_re),
        .raddr (ram_raddr),
        .rdata (ram_rdata)
    );

    assign stat.cmd          = cmd_reg;
    assign stat.full         = (count_reg == CW'(MAX_FACES));
    assign stat.query_ok     = (count_reg >= CW'(2)) && (32'(xi_reg) < 32'(MAX_SAMPLES));
    assign stat.mac_last     = (cnt_reg == CNT_W'(FACE_VERTICES - 1));
    assign stat.in_range     = (xs >= ext46(d_lo_reg)) && (xs < ext46(rd_dist));
    assign stat.search_more  = {1'b0, hi_reg} > ({1'b0, lo_reg} + (AW+1)'(1));
    assign stat.frac_special = den_le0 || num_le0 || num_ge_den;
    assign stat.div_last     = (cnt_reg == CNT_W'(DIV_BITS - 1));
    assign stat.out_free     = !out_valid_reg || !out_stall;

    assign out_valid     = out_valid_reg;
    assign status        = out_status_reg;
    assign in_cells      = out_in_cells_reg;
    assign segment_index = out_seg_reg;
    assign sample_value  = out_value_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            delta_x_reg   <= DELTA_X_RESET;
            count_reg     <= '0;
            cnt_reg       <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            if (cfg_wr_en)
            begin
                delta_x_reg <= cfg_wr_data;
            end
            if (ctl.op == DP_CLEAR)
            begin
                count_reg <= '0;
            end
            else if (ctl.op == DP_WRITE)
            begin
                count_reg <= count_reg + CW'(1);
            end
            if ((ctl.op == DP_LOAD) || (ctl.op == DP_FRAC))
            begin
                cnt_reg <= '0;
            end
            else if ((ctl.op == DP_MAC) || (ctl.op == DP_DIV))
            begin
                cnt_reg <= cnt_reg + CNT_W'(1);
            end
            if (ctl.op == DP_OUTLOAD)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (!out_stall)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        unique case (ctl.op)
            DP_LOAD:
            begin
                cmd_reg     <= cmd;
                dist_in_reg <= face_dist;
                vert_reg_0  <= vert_value_0;
                vert_reg_1  <= vert_value_1;
                vert_reg_2  <= vert_value_2;
                bary_reg_0  <= bary_0;
                bary_reg_1  <= bary_1;
                bary_reg_2  <= bary_2;
                xi_reg      <= sample_index;
                prod_reg    <= '0;
                acc_reg     <= '0;
            end
            DP_MAC:
            begin
                prod_reg <= mac_prod;
                acc_reg  <= acc_reg + $signed({{2{prod_reg[49]}}, prod_reg});
            end
            DP_MACEND:
            begin
                acc_reg <= acc_reg + $signed({{2{prod_reg[49]}}, prod_reg});
            end
            DP_XMUL:
            begin
                x_reg <= delta_x_reg * xi_reg;
            end
            DP_CAPLO:
            begin
                d_lo_reg <= rd_dist;
                v_lo_reg <= rd_val;
                lo_reg   <= '0;
                hi_reg   <= last_idx;
            end
            DP_CAPHI:
            begin
                d_hi_reg <= rd_dist;
                v_hi_reg <= rd_val;
            end
            DP_SEARCH:
            begin
                mid_reg <= mid;
            end
            DP_SCMP:
            begin
                if (rd_gt_x)
                begin
                    hi_reg   <= mid_reg;
                    d_hi_reg <= rd_dist;
                    v_hi_reg <= rd_val;
                end
                else
                begin
                    lo_reg   <= mid_reg;
                    d_lo_reg <= rd_dist;
                    v_lo_reg <= rd_val;
                end
            end
            DP_DIVINIT:
            begin
                num_reg  <= xs - ext46(d_lo_reg);
                den_reg  <= $signed({d_hi_reg[31], d_hi_reg}) - $signed({d_lo_reg[31], d_lo_reg});
                diff_reg <= $signed({v_hi_reg[31], v_hi_reg}) - $signed({v_lo_reg[31], v_lo_reg});
            end
            DP_FRAC:
            begin
                rem_reg <= num_reg[32:0];
                priority if (den_le0 || num_le0)
                begin
                    frac_reg <= '0;
                end
                else if (num_ge_den)
                begin
                    frac_reg <= FRAC_ONE;
                end
                else
                begin
                    frac_reg <= '0;
                end
            end
            DP_DIV:
            begin
                rem_reg  <= rem_next;
                frac_reg <= {frac_reg[15:0], div_ge};
            end
            DP_VMUL:
            begin
                mprod_reg <= $signed({1'b0, frac_reg}) * diff_reg;
            end
            DP_VFIN:
            begin
                res_status_reg   <= 1'b0;
                res_in_cells_reg <= 1'b1;
                res_seg_reg      <= lo_ext[5:0];
                res_value_reg    <= sat32(vsum);
            end
            DP_CLEAR, DP_WRITE, DP_RES_ZERO:
            begin
                res_status_reg   <= 1'b0;
                res_in_cells_reg <= 1'b0;
                res_seg_reg      <= '0;
                res_value_reg    <= '0;
            end
            DP_RES_FULL:
            begin
                res_status_reg   <= 1'b1;
                res_in_cells_reg <= 1'b0;
                res_seg_reg      <= '0;
                res_value_reg    <= '0;
            end
            DP_OUTLOAD:
            begin
                out_status_reg   <= res_status_reg;
                out_in_cells_reg <= res_in_cells_reg;
                out_seg_reg      <= res_seg_reg;
                out_value_reg    <= res_value_reg;
            end
            default:
            begin
            end
        endcase
    end

endmodule

// ===== hw/rtl/rfr_checker.sv =====
module rfr_checker (
    input logic        clk,
    input logic        rst_n,
    input logic        in_valid,
    input logic        in_stall,
    input logic        out_valid,
    input logic        out_stall,
    input logic        status,
    input logic        in_cells,
    input logic [5:0]  segment_index,
    input logic [31:0] sample_value
);

    // result word holds while stalled
    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && out_stall |=> out_valid && $stable(status) && $stable(in_cells)
            && $stable(segment_index) && $stable(sample_value))
        else $error("result word changed while stalled");

    // only one word is worked on at a time
    a_busy_after_accept: assert property (@(posedge clk) disable iff (!rst_n)
        in_valid && !in_stall |=> in_stall)
        else $error("input taken again right after an accept");

    // a sample inside the mesh never carries a refused append
    a_inside_ok: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && in_cells |-> !status)
        else $error("in_cells with status set");

    // outside samples and table commands report zero index and value
    a_outside_zero: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !in_cells |-> (segment_index == 6'd0) && (sample_value == 32'd0))
        else $error("nonzero payload with in_cells clear");

endmodule

bind ray_face_resampler_core rfr_checker u_rfr_checker (.*);
